/* sv/lbc_pkg.sv */
// Shared types and codes for the LRU block cache.
`timescale 1ns / 1ps
`default_nettype none
package lbc_pkg;
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;

  localparam logic CFG_ENABLED = 1'b0;
  localparam logic CFG_ENTRIES = 1'b1;

  localparam logic [6:0] ENTRIES_RESET = 7'd64;

  // Item kinds as sorted by the front end.
  localparam logic [2:0] K_LOOKUP = 3'd0;
  localparam logic [2:0] K_BAD    = 3'd1;
  localparam logic [2:0] K_INS0   = 3'd2;
  localparam logic [2:0] K_UPD0   = 3'd3;
  localparam logic [2:0] K_WORD   = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  disk;
    logic [7:0]  blk;
    logic [4:0]  word_index;
    logic [63:0] data_word;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;
endpackage
`default_nettype wire

/* sv/lbc_ram.sv */
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module lbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* sv/lbc_front.sv */
// Front end: accepts items, sorts them by kind and queues them for the engine.
`timescale 1ns / 1ps
`default_nettype none
module lbc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  logic [1:0]    op,
  input  logic [3:0]    disk,
  input  logic [7:0]    blk,
  input  logic [4:0]    word_index,
  input  logic [63:0]   data_word,
  input  logic          pop,
  output lbc_pkg::head_t head
);
  import lbc_pkg::*;

  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      item_in;
  logic       push;

  always_comb begin
    item_in.disk       = disk;
    item_in.blk        = blk;
    item_in.word_index = word_index;
    item_in.data_word  = data_word;
    unique case (op)
      OP_LOOKUP: item_in.kind = K_LOOKUP;
      OP_INSERT: item_in.kind = (word_index == 5'd0) ? K_INS0 : K_WORD;
      OP_UPDATE: item_in.kind = (word_index == 5'd0) ? K_UPD0 : K_WORD;
      default:   item_in.kind = K_BAD;
    endcase
  end

  assign req_stall  = (count == 2'd2);
  assign push       = req_valid && !req_stall;
  assign head.valid = (count != 2'd0);
  assign head.item  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item_in;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

/* sv/lbc_back.sv */
// Back end: slot search, LRU choice, block storage and the result register.
`timescale 1ns / 1ps
`default_nettype none
module lbc_back #(
  parameter int MAX_ENTRIES = 64,
  parameter int BLOCK_WORDS = 32,
  parameter int TIME_WIDTH  = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [6:0]    cfg_data,
  input  lbc_pkg::head_t head,
  output logic          pop,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output logic          status,
  output logic [63:0]   read_word,
  output logic [4:0]    read_index,
  output logic          final_res
);
  import lbc_pkg::*;

  localparam int SW  = $clog2(MAX_ENTRIES);
  localparam int NW  = (SW + 1 > 7) ? SW + 1 : 7;
  localparam int KW  = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
  localparam int DD  = MAX_ENTRIES * BLOCK_WORDS;
  localparam int DAW = (DD > 1) ? $clog2(DD) : 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_DECIDE  = 3'd2;
  localparam logic [2:0] S_RD_ADDR = 3'd3;
  localparam logic [2:0] S_RD_DATA = 3'd4;
  localparam logic [2:0] S_RESP    = 3'd5;

  logic [2:0]             state;
  logic                   enabled;
  logic [6:0]             entries;
  logic [MAX_ENTRIES-1:0] valid_q;
  logic [TIME_WIDTH-1:0]  time_cnt;
  logic                   inserted;
  logic                   pend_fail;
  logic [DAW-1:0]         pend_base;
  logic                   resp_status;

  logic [SW-1:0]          scan_addr;
  logic                   iss_on;
  logic                   cmp_vld;
  logic [SW-1:0]          cmp_idx;
  logic                   hit_found;
  logic [SW-1:0]          hit_idx;
  logic                   inv_found;
  logic [SW-1:0]          inv_idx;
  logic [SW-1:0]          min_idx;
  logic [TIME_WIDTH-1:0]  min_stamp;
  logic [KW-1:0]          k;
  logic [DAW-1:0]         dat_raddr;

  logic [NW-1:0]          n_cnt;
  logic [SW-1:0]          n_m1;
  logic                   out_free;
  logic                   word_ok;
  logic                   k_last;
  logic [SW-1:0]          ins_slot;
  item_t                  it;

  logic                   tag_we;
  logic [SW-1:0]          tag_waddr;
  logic [11:0]            tag_rd;
  logic                   stamp_we;
  logic [SW-1:0]          stamp_waddr;
  logic [TIME_WIDTH-1:0]  stamp_wdata;
  logic [TIME_WIDTH-1:0]  stamp_rd;
  logic                   dat_we;
  logic [DAW-1:0]         dat_waddr;
  logic [63:0]            dat_rd;

  function automatic logic [DAW-1:0] slot_base(input logic [SW-1:0] s);
    slot_base = DAW'(DAW'(s) * DAW'(BLOCK_WORDS));
  endfunction

  assign it       = head.item;
  assign out_free = !rsp_valid || !rsp_stall;
  assign k_last   = (k == KW'(BLOCK_WORDS - 1));
  assign ins_slot = inv_found ? inv_idx : min_idx;
  assign word_ok  = enabled && !pend_fail && (int'(it.word_index) < BLOCK_WORDS);

  always_comb begin
    n_cnt = NW'(entries);
    if (n_cnt < NW'(2)) begin
      n_cnt = NW'(2);
    end else if (n_cnt > NW'(MAX_ENTRIES)) begin
      n_cnt = NW'(MAX_ENTRIES);
    end
    n_m1 = SW'(n_cnt - NW'(1));
  end

  always_comb begin
    tag_we      = 1'b0;
    tag_waddr   = ins_slot;
    stamp_we    = 1'b0;
    stamp_waddr = hit_idx;
    stamp_wdata = time_cnt + TIME_WIDTH'(1);
    dat_we      = 1'b0;
    dat_waddr   = pend_base + DAW'(it.word_index);
    pop         = 1'b0;
    unique case (state)
      S_IDLE: begin
        dat_we = head.valid && (it.kind == K_WORD) && word_ok;
      end
      S_DECIDE: begin
        unique case (it.kind)
          K_LOOKUP: begin
            stamp_we = hit_found;
          end
          K_INS0: begin
            tag_we      = !hit_found;
            stamp_we    = !hit_found;
            stamp_waddr = ins_slot;
            dat_we      = !hit_found;
            dat_waddr   = slot_base(ins_slot);
          end
          K_UPD0: begin
            stamp_we    = hit_found;
            stamp_wdata = time_cnt;
            dat_we      = hit_found;
            dat_waddr   = slot_base(hit_idx);
          end
          default: begin
          end
        endcase
      end
      S_RD_DATA: pop = out_free && k_last;
      S_RESP:    pop = out_free;
      default: begin
      end
    endcase
  end

  lbc_ram #(.WIDTH(12), .DEPTH(MAX_ENTRIES)) u_tag (
    .clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata({it.disk, it.blk}),
    .raddr(scan_addr), .rdata(tag_rd)
  );

  lbc_ram #(.WIDTH(TIME_WIDTH), .DEPTH(MAX_ENTRIES)) u_stamp (
    .clk(clk), .we(stamp_we), .waddr(stamp_waddr), .wdata(stamp_wdata),
    .raddr(scan_addr), .rdata(stamp_rd)
  );

  lbc_ram #(.WIDTH(64), .DEPTH(DD)) u_data (
    .clk(clk), .we(dat_we), .waddr(dat_waddr), .wdata(it.data_word),
    .raddr(dat_raddr), .rdata(dat_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      enabled   <= 1'b0;
      entries   <= ENTRIES_RESET;
      valid_q   <= '0;
      time_cnt  <= '0;
      inserted  <= 1'b0;
      pend_fail <= 1'b0;
      pend_base <= '0;
      rsp_valid <= 1'b0;
      iss_on    <= 1'b0;
      cmp_vld   <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_index == CFG_ENABLED) begin
          enabled   <= cfg_data[0];
          valid_q   <= '0;
          inserted  <= 1'b0;
          pend_fail <= 1'b1;
        end else begin
          entries <= cfg_data;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (head.valid) begin
            scan_addr <= '0;
            iss_on    <= 1'b1;
            cmp_vld   <= 1'b0;
            hit_found <= 1'b0;
            inv_found <= 1'b0;
            unique case (it.kind)
              K_LOOKUP: begin
                if (enabled && inserted) begin
                  state <= S_SCAN;
                end else begin
                  resp_status <= 1'b1;
                  state       <= S_RESP;
                end
              end
              K_INS0, K_UPD0: begin
                if (enabled) begin
                  state <= S_SCAN;
                end else begin
                  pend_fail   <= 1'b1;
                  resp_status <= 1'b1;
                  state       <= S_RESP;
                end
              end
              K_WORD: begin
                resp_status <= !word_ok;
                state       <= S_RESP;
              end
              default: begin
                resp_status <= 1'b1;
                state       <= S_RESP;
              end
            endcase
          end
        end
        S_SCAN: begin
          // The compare works on RAM data for the address issued in the cycle before.
          cmp_vld <= iss_on;
          cmp_idx <= scan_addr;
          if (iss_on) begin
            if (scan_addr == n_m1) begin
              iss_on <= 1'b0;
            end else begin
              scan_addr <= scan_addr + SW'(1);
            end
          end
          if (cmp_vld) begin
            if (valid_q[cmp_idx] && tag_rd == {it.disk, it.blk} && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx   <= cmp_idx;
            end
            if (!valid_q[cmp_idx] && !inv_found) begin
              inv_found <= 1'b1;
              inv_idx   <= cmp_idx;
            end
            // Strict compare keeps the lowest slot on equal stamps.
            if (cmp_idx == '0 || stamp_rd < min_stamp) begin
              min_stamp <= stamp_rd;
              min_idx   <= cmp_idx;
            end
            if (cmp_idx == n_m1) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          unique case (it.kind)
            K_LOOKUP: begin
              if (hit_found) begin
                time_cnt  <= time_cnt + TIME_WIDTH'(1);
                dat_raddr <= slot_base(hit_idx);
                k         <= '0;
                state     <= S_RD_ADDR;
              end else begin
                resp_status <= 1'b1;
                state       <= S_RESP;
              end
            end
            K_INS0: begin
              if (hit_found) begin
                pend_fail   <= 1'b1;
                resp_status <= 1'b1;
              end else begin
                valid_q[ins_slot] <= 1'b1;
                time_cnt          <= time_cnt + TIME_WIDTH'(1);
                inserted          <= 1'b1;
                pend_base         <= slot_base(ins_slot);
                pend_fail         <= 1'b0;
                resp_status       <= 1'b0;
              end
              state <= S_RESP;
            end
            default: begin
              if (hit_found) begin
                pend_base   <= slot_base(hit_idx);
                pend_fail   <= 1'b0;
                resp_status <= 1'b0;
              end else begin
                pend_fail   <= 1'b1;
                resp_status <= 1'b1;
              end
              state <= S_RESP;
            end
          endcase
        end
        S_RD_ADDR: begin
          state <= S_RD_DATA;
        end
        S_RD_DATA: begin
          if (out_free) begin
            rsp_valid  <= 1'b1;
            status     <= 1'b0;
            read_word  <= dat_rd;
            read_index <= 5'(k);
            final_res  <= k_last;
            if (k_last) begin
              state <= S_IDLE;
            end else begin
              k         <= k + KW'(1);
              dat_raddr <= dat_raddr + DAW'(1);
              state     <= S_RD_ADDR;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            rsp_valid  <= 1'b1;
            status     <= resp_status;
            read_word  <= '0;
            read_index <= '0;
            final_res  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

/* sv/lru_block_cache_core.sv */
// Scan: when enabled, a lookup (after an insert) or word-0 insert/update scans entries_in_use
// slots, one per cycle, through the tag and stamp RAM read port, then passes a decide state.
// A hit then streams its words from the block RAM via address and data states, holding on a stall;
// other words just respond. One item at a time in the engine; a 2-item queue lets the input run ahead.
// Reset clears control state and all valid marks at once; no clearing pass is needed.
// Tag, stamp and block data RAMs are not reset.
`timescale 1ns / 1ps
`default_nettype none
module lru_block_cache_core #(
  parameter int MAX_ENTRIES = 64,
  parameter int BLOCK_WORDS = 32,
  parameter int TIME_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  op,
  input  logic [3:0]  disk,
  input  logic [7:0]  blk,
  input  logic [4:0]  word_index,
  input  logic [63:0] data_word,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        status,
  output logic [63:0] read_word,
  output logic [4:0]  read_index,
  output logic        final_res
);
  import lbc_pkg::*;

  head_t head;
  logic  pop;

  lbc_front u_front (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
    .op(op), .disk(disk), .blk(blk), .word_index(word_index),
    .data_word(data_word), .pop(pop), .head(head)
  );

  lbc_back #(
    .MAX_ENTRIES(MAX_ENTRIES), .BLOCK_WORDS(BLOCK_WORDS), .TIME_WIDTH(TIME_WIDTH)
  ) u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .head(head), .pop(pop), .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall), .status(status), .read_word(read_word),
    .read_index(read_index), .final_res(final_res)
  );
endmodule
`default_nettype wire

/* sv/lbc_checker.sv */
// Port-level checks on the result channel of the cache, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lbc_props (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic        status,
  input logic [63:0] read_word,
  input logic [4:0]  read_index,
  input logic        final_res
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(read_word) && $stable(read_index))
    else $error("stalled result changed");

  a_fail_final: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status |-> final_res && read_word == 64'd0 && read_index == 5'd0)
    else $error("failure result is not a lone final item");

  a_stream_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !final_res |-> !status)
    else $error("non-final result carries failure");

  a_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");
endmodule

bind lru_block_cache_core lbc_props u_lbc_props (
  .clk(clk), .rst(rst), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
  .status(status), .read_word(read_word), .read_index(read_index),
  .final_res(final_res)
);
`default_nettype wire
